[hdl/y2r_pkg.sv]
package y2r_pkg;

    localparam int PixW  = 8;
    localparam int ProdW = 18;
    localparam int SumW  = 20;

    localparam logic [PixW-1:0] LumaOfs   = 8'd16;
    localparam logic [PixW-1:0] ChromaOfs = 8'd128;
    localparam logic [PixW-1:0] AlphaOpaque = 8'd255;

    localparam logic signed [ProdW-1:0] KY  = 18'sd298;
    localparam logic signed [ProdW-1:0] KRV = 18'sd409;
    localparam logic signed [ProdW-1:0] KGU = 18'sd100;
    localparam logic signed [ProdW-1:0] KGV = 18'sd208;
    localparam logic signed [ProdW-1:0] KBU = 18'sd516;
    localparam logic signed [SumW-1:0]  KRound = 20'sd128;

    localparam logic [1:0] CfgAlphaInSource = 2'd0;
    localparam logic [1:0] CfgAlphaOut      = 2'd1;

    // per-stage advance strobes of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } y2r_adv_t;

    typedef struct packed {
        logic [PixW-1:0] blue;
        logic [PixW-1:0] green;
        logic [PixW-1:0] red;
    } y2r_rgb_t;

    // floor(sum/256) clamped to 0..255
    function automatic logic [PixW-1:0] clamp_chan(input logic signed [SumW-1:0] sum);
        logic [PixW-1:0] r;
        if (sum[SumW-1])
            r = '0;
        else if (|sum[SumW-2:16])
            r = 8'hFF;
        else
            r = sum[15:8];
        return r;
    endfunction

endpackage

[hdl/y2r_pixel.sv]
module y2r_pixel
    import y2r_pkg::*;
(
    input  logic            clk,
    input  y2r_adv_t        adv,
    input  logic [PixW-1:0] luma,
    input  logic [PixW-1:0] chroma_blue,
    input  logic [PixW-1:0] chroma_red,
    output y2r_rgb_t        rgb
);

    logic signed [8:0] c_val;
    logic signed [8:0] d_val;
    logic signed [8:0] e_val;

    logic signed [ProdW-1:0] py_reg, prv_reg, pgu_reg, pgv_reg, pbu_reg;
    logic signed [SumW-1:0]  sr_reg, sg_reg, sb_reg;
    y2r_rgb_t                rgb_reg;

    assign c_val = $signed({1'b0, luma} - {1'b0, LumaOfs});
    assign d_val = $signed({1'b0, chroma_blue} - {1'b0, ChromaOfs});
    assign e_val = $signed({1'b0, chroma_red} - {1'b0, ChromaOfs});

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            py_reg  <= ProdW'(c_val) * KY;
            prv_reg <= ProdW'(e_val) * KRV;
            pgu_reg <= ProdW'(d_val) * KGU;
            pgv_reg <= ProdW'(e_val) * KGV;
            pbu_reg <= ProdW'(d_val) * KBU;
        end
        if (adv.s2)
        begin
            sr_reg <= SumW'(py_reg) + SumW'(prv_reg) + KRound;
            sg_reg <= SumW'(py_reg) - SumW'(pgu_reg) - SumW'(pgv_reg) + KRound;
            sb_reg <= SumW'(py_reg) + SumW'(pbu_reg) + KRound;
        end
        if (adv.s3)
        begin
            rgb_reg.red   <= clamp_chan(sr_reg);
            rgb_reg.green <= clamp_chan(sg_reg);
            rgb_reg.blue  <= clamp_chan(sb_reg);
        end
    end

    assign rgb = rgb_reg;

endmodule

[hdl/yuv422_pair_to_rgb.sv]
// channel   dir  signals                        word
// s_axis    in   s_tvalid s_tready s_tdata[47:0] one YUV 4:2:2 pair (+ two alpha)
// m_axis    out  m_tvalid m_tready m_tdata[63:0] two RGBA pixels
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Three register stages: constant products, channel sums, clamp into the
// output register. One pair per cycle sustained while m_tready stays high.
// rst_n clears the valid bits and both config registers.
// A stall at m_tready holds each full stage whose later stages are all full; empty
// stages still fill, and s_tready drops only when all three stages are full and stalled.
module yuv422_pair_to_rgb
    import y2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // luma_first, chroma_blue, luma_second, chroma_red, alpha_first_in, alpha_second_in
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_first, green_first, blue_first, alpha_first_out,
    // red_second, green_second, blue_second, alpha_second_out
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    logic alpha_in_source_reg;
    logic alpha_out_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic [PixW-1:0] a1_s1_reg, a2_s1_reg, a1_s2_reg, a2_s2_reg, a1_s3_reg, a2_s3_reg;
    logic [PixW-1:0] a1_next, a2_next;
    y2r_adv_t adv;
    y2r_rgb_t rgb1, rgb2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_in_source_reg <= 1'b0;
            alpha_out_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgAlphaInSource: alpha_in_source_reg <= cfg_data;
                CfgAlphaOut:      alpha_out_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign adv.s3   = !v3_reg || m_tready;
    assign adv.s2   = !v2_reg || adv.s3;
    assign adv.s1   = !v1_reg || adv.s2;
    assign s_tready = adv.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv.s1)
                v1_reg <= s_tvalid;
            if (adv.s2)
                v2_reg <= v1_reg;
            if (adv.s3)
                v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        if (!alpha_out_reg)
        begin
            a1_next = '0;
            a2_next = '0;
        end
        else if (alpha_in_source_reg)
        begin
            a1_next = s_tdata[39:32];
            a2_next = s_tdata[47:40];
        end
        else
        begin
            a1_next = AlphaOpaque;
            a2_next = AlphaOpaque;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            a1_s1_reg <= a1_next;
            a2_s1_reg <= a2_next;
        end
        if (adv.s2)
        begin
            a1_s2_reg <= a1_s1_reg;
            a2_s2_reg <= a2_s1_reg;
        end
        if (adv.s3)
        begin
            a1_s3_reg <= a1_s2_reg;
            a2_s3_reg <= a2_s2_reg;
        end
    end

    y2r_pixel u_pix_first (
        .clk         (clk),
        .adv         (adv),
        .luma        (s_tdata[7:0]),
        .chroma_blue (s_tdata[15:8]),
        .chroma_red  (s_tdata[31:24]),
        .rgb         (rgb1)
    );

    y2r_pixel u_pix_second (
        .clk         (clk),
        .adv         (adv),
        .luma        (s_tdata[23:16]),
        .chroma_blue (s_tdata[15:8]),
        .chroma_red  (s_tdata[31:24]),
        .rgb         (rgb2)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {a2_s3_reg, rgb2.blue, rgb2.green, rgb2.red,
                       a1_s3_reg, rgb1.blue, rgb1.green, rgb1.red};

endmodule

[test/rgb_pair_checker.sv]
module rgb_pair_checker
    import y2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        final_check,
    output int          pending,
    output int          fail_count
);

    // first field sits in the lowest bits, so it is declared last
    typedef struct packed {
        logic [PixW-1:0] alpha_second;
        logic [PixW-1:0] alpha_first;
        logic [PixW-1:0] chroma_red;
        logic [PixW-1:0] luma_second;
        logic [PixW-1:0] chroma_blue;
        logic [PixW-1:0] luma_first;
    } yuv_pair_t;

    localparam int MaxPrinted = 20;

    logic        alpha_src_q;
    logic        alpha_out_q;
    logic [63:0] rgba_pairs[$];
    logic [63:0] want;
    bit          leftovers_checked;

    string field_names[8] = '{"red_first", "green_first", "blue_first", "alpha_first_out",
                              "red_second", "green_second", "blue_second", "alpha_second_out"};

    // studio-range sum -> 0..255, floor of sum/256
    function automatic logic [PixW-1:0] saturate_chan(int sum);
        int scaled;
        if (sum < 0)
            return '0;
        scaled = sum >>> 8;
        if (scaled > 255)
            return 8'hFF;
        return scaled[PixW-1:0];
    endfunction

    // returns {blue, green, red}
    function automatic logic [23:0] pixel_rgb(logic [PixW-1:0] luma, int du, int dv);
        int c;
        c = int'(luma) - 16;
        return {saturate_chan(298 * c + 516 * du + 128),
                saturate_chan(298 * c - 100 * du - 208 * dv + 128),
                saturate_chan(298 * c + 409 * dv + 128)};
    endfunction

    function automatic logic [63:0] convert_pair(yuv_pair_t px, logic src_alpha, logic out_alpha);
        int du;
        int dv;
        logic [PixW-1:0] a1;
        logic [PixW-1:0] a2;
        du = int'(px.chroma_blue) - 128;
        dv = int'(px.chroma_red) - 128;
        a1 = '0;
        a2 = '0;
        if (out_alpha)
        begin
            a1 = src_alpha ? px.alpha_first : 8'hFF;
            a2 = src_alpha ? px.alpha_second : 8'hFF;
        end
        return {a2, pixel_rgb(px.luma_second, du, dv), a1, pixel_rgb(px.luma_first, du, dv)};
    endfunction

    task automatic report(string msg);
        fail_count++;
        if (fail_count <= MaxPrinted)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_src_q = 1'b0;
            alpha_out_q = 1'b0;
            rgba_pairs.delete();
            pending = 0;
            fail_count = 0;
            leftovers_checked = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (rgba_pairs.size() == 0)
                    report($sformatf("result word %h with nothing expected", m_tdata));
                else
                begin
                    want = rgba_pairs.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (m_tdata[8*i +: 8] !== want[8*i +: 8])
                            report($sformatf("%s: got %0d, want %0d", field_names[i],
                                             m_tdata[8*i +: 8], want[8*i +: 8]));
                end
            end
            if (s_tvalid && s_tready)
                rgba_pairs.push_back(convert_pair(yuv_pair_t'(s_tdata), alpha_src_q, alpha_out_q));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgAlphaInSource: alpha_src_q = cfg_data;
                    CfgAlphaOut:      alpha_out_q = cfg_data;
                    default:          ;
                endcase
            end
            if (final_check && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (rgba_pairs.size() != 0)
                    report($sformatf("%0d expected words never came", rgba_pairs.size()));
            end
            pending = rgba_pairs.size();
        end
    end

endmodule

[test/testbench.sv]
module testbench;
    import y2r_pkg::*;

    // indexes past the register list, writes there must change nothing
    localparam logic [1:0] CfgSpareA = 2'd2;
    localparam logic [1:0] CfgSpareB = 2'd3;
    localparam int CycleLimit = 200000;
    localparam int Phases = 8;
    localparam int PairsPerPhase = 219;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CfgAlphaInSource;
    logic        cfg_data = 1'b0;
    logic        final_check = 1'b0;
    int          pending;
    int          fail_count;
    int          cycles = 0;
    int          tx_idle_pct = 33;
    int          rx_idle_pct = 33;

    yuv422_pair_to_rgb dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rgb_pair_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .final_check(final_check), .pending(pending), .fail_count(fail_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= rx_idle_pct);

    task automatic send_pair(logic [7:0] y1, logic [7:0] u, logic [7:0] y2, logic [7:0] v,
                             logic [7:0] a1, logic [7:0] a2);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata = {a2, a1, v, y2, u, y1};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and let the pipe empty out
    task automatic drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // favor the extremes now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: no alpha out, source alpha ignored
        send_pair(16, 128, 16, 128, 8'hA5, 8'h5A);
        send_pair(235, 128, 235, 128, 8'h00, 8'hFF);
        send_pair(0, 0, 0, 0, 8'hFF, 8'h00);
        send_pair(255, 255, 255, 255, 8'hFF, 8'hFF);
        send_pair(0, 255, 255, 0, 8'h0F, 8'hF0);
        send_pair(255, 0, 0, 255, 8'h33, 8'hCC);
        send_pair(16, 0, 235, 255, 8'h01, 8'h80);
        send_pair(128, 128, 128, 128, 8'h7F, 8'hFE);
        drain();
        write_reg(CfgAlphaInSource, 1'b1);
        send_pair(100, 90, 200, 240, 8'hFF, 8'hFF);
        send_pair(60, 200, 30, 20, 8'h12, 8'h34);
        drain();
        write_reg(CfgAlphaOut, 1'b1);
        send_pair(81, 90, 145, 54, 8'h00, 8'hFF);
        send_pair(210, 16, 41, 110, 8'hFF, 8'h00);
        send_pair(255, 255, 0, 0, 8'h80, 8'h7F);
        drain();
        write_reg(CfgAlphaInSource, 1'b0);
        send_pair(81, 90, 145, 54, 8'h00, 8'h00);
        send_pair(0, 128, 255, 128, 8'h33, 8'hCC);
        drain();
        write_reg(CfgSpareA, 1'b1);
        write_reg(CfgSpareB, 1'b0);
        send_pair(120, 60, 180, 200, 8'h11, 8'h22);
        send_pair(30, 250, 240, 5, 8'hEE, 8'hDD);

        for (int p = 0; p < Phases; p++)
        begin
            drain();
            if ($urandom_range(1))
            begin
                write_reg(CfgAlphaInSource, p[0]);
                write_reg(CfgAlphaOut, p[1]);
            end
            else
            begin
                write_reg(CfgAlphaOut, p[1]);
                write_reg(CfgAlphaInSource, p[0]);
            end
            if (p == 5)
                write_reg($urandom_range(1) ? CfgSpareA : CfgSpareB, 1'($urandom_range(1)));
            // one phase runs flat out on both sides
            tx_idle_pct = (p == 3) ? 0 : 33;
            rx_idle_pct = (p == 3) ? 0 : 33;
            for (int n = 0; n < PairsPerPhase; n++)
                send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                          pick_byte(), pick_byte());
        end

        drain();
        repeat (8) @(negedge clk);
        final_check = 1'b1;
        repeat (2) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/y2r_pkg.sv
hdl/y2r_pixel.sv
hdl/yuv422_pair_to_rgb.sv
test/rgb_pair_checker.sv
test/testbench.sv
